### rtl/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared types and constants of the 2x2x2 volume box downsampler.
// ----------------------------------------------------------------------------
package vbd_pkg;

    // Register map, one 32-bit word per register at byte address 4*index.
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_IMAGE_DEPTH  = 2'd2
    } cfg_reg_t;

    localparam int unsigned CFG_ADDR_BITS = 4;
    localparam int unsigned CFG_DATA_BITS = 32;

    localparam int unsigned WIDTH_BITS  = 10;
    localparam int unsigned HEIGHT_BITS = 10;
    localparam int unsigned DEPTH_BITS  = 16;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 10'd512;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 10'd512;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_RESET  = 16'd512;

    localparam int unsigned IN_BITS   = 16;
    localparam int unsigned PAIR_BITS = 17;
    localparam int unsigned QUAD_BITS = 18;
    localparam int unsigned CUBE_BITS = 19;

    // Dimensions after clamping to their legal ranges.
    typedef struct packed {
        logic [WIDTH_BITS-1:0]  width;
        logic [HEIGHT_BITS-1:0] height;
        logic [DEPTH_BITS-1:0]  depth;
    } dims_t;

    // Position flags of a voxel held in the working stage.
    typedef struct packed {
        logic in_grid;
        logic x_odd;
        logic y_odd;
        logic z_odd;
        logic last;
    } pos_flags_t;

endpackage

### rtl/vbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// vbd_cfg_regs
// Configuration registers with an APB-style port; gives the clamped sizes.
// ----------------------------------------------------------------------------
module vbd_cfg_regs
    import vbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output dims_t                    dims
);

    // A 10-bit register never exceeds 1023, so the cap only matters below that.
    localparam int WIDTH_CAP  = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam int HEIGHT_CAP = (MAX_HEIGHT > 1023) ? 1023 : MAX_HEIGHT;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic                   wr_en;
    cfg_reg_t               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            depth_reg  <= DEPTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_BITS-1:0];
                REG_IMAGE_DEPTH:  depth_reg  <= pwdata[DEPTH_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_BITS'(height_reg);
            REG_IMAGE_DEPTH:  prdata = CFG_DATA_BITS'(depth_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (width_reg < 10'd2)
            dims.width = 10'd2;
        else if (width_reg > WIDTH_BITS'(WIDTH_CAP))
            dims.width = WIDTH_BITS'(WIDTH_CAP);
        else
            dims.width = width_reg;

        if (height_reg < 10'd2)
            dims.height = 10'd2;
        else if (height_reg > HEIGHT_BITS'(HEIGHT_CAP))
            dims.height = HEIGHT_BITS'(HEIGHT_CAP);
        else
            dims.height = height_reg;

        dims.depth = (depth_reg < 16'd2) ? 16'd2 : depth_reg;
    end

endmodule

### rtl/volume_box_downsample_2x_core.sv
// ----------------------------------------------------------------------------
// volume_box_downsample_2x_core
// 2x2x2 box-filter downsampler for a volume streamed in raster order.
// ----------------------------------------------------------------------------
// Voxels enter on the voxel channel (voxel_valid / voxel_stall), x fastest,
// then y, then z. For each aligned 2x2x2 cube one word leaves on the result
// channel (result_valid / result_stall): the truncated mean of its eight
// voxels, with volume_done set on the last word of the volume. A trailing odd
// column, row or slice is consumed and produces nothing.
// One voxel is taken per cycle while voxel_stall is low. A voxel is held in a
// working register while the row and slice buffers are read, and its word
// then passes from that register into the output register.
// When the receiver stalls, the working stage keeps taking voxels that make
// no word; a voxel that completes a cube waits there and stalls the input.
// Sizes are to be written through the APB port only while idle; the block does
// not enforce this. Reset clears the position counters and both pipeline stages
// at once; buffers need no clearing: every entry is written before it is read.
// ----------------------------------------------------------------------------
module volume_box_downsample_2x_core
    import vbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int VOXEL_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     voxel_valid,
    output logic                     voxel_stall,
    input  logic [IN_BITS-1:0]       voxel,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [IN_BITS-1:0]       average,
    output logic                     volume_done
);

    localparam int ROW_DEPTH   = MAX_WIDTH / 2;
    localparam int SLICE_DEPTH = ROW_DEPTH * (MAX_HEIGHT / 2);
    localparam int ROW_AW      = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int SLICE_AW    = (SLICE_DEPTH > 1) ? $clog2(SLICE_DEPTH) : 1;

    dims_t dims;

    vbd_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // Position counters of the next voxel.
    logic [WIDTH_BITS-1:0]  column_count_reg, column_count_next;
    logic [HEIGHT_BITS-1:0] row_count_reg, row_count_next;
    logic [DEPTH_BITS-1:0]  slice_count_reg, slice_count_next;

    // Working stage.
    logic                  s1_valid_reg, s1_valid_next;
    logic [VOXEL_BITS-1:0] s1_voxel_reg;
    pos_flags_t            s1_flags_reg, s1_flags_next;
    logic [ROW_AW-1:0]     s1_row_addr_reg;
    logic [SLICE_AW-1:0]   s1_slice_addr_reg;
    logic [VOXEL_BITS-1:0] even_voxel_reg;

    // Buffers and their registered read data.
    logic [PAIR_BITS-1:0] row_mem [ROW_DEPTH];
    logic [QUAD_BITS-1:0] slice_mem [SLICE_DEPTH];
    logic [PAIR_BITS-1:0] row_rd_reg;
    logic [QUAD_BITS-1:0] slice_rd_reg;

    // Output register.
    logic                 result_valid_reg, result_valid_next;
    logic [IN_BITS-1:0]   average_reg;
    logic                 volume_done_reg;

    logic                    voxel_accept;
    logic                    s1_emit;
    logic                    s1_adv;
    logic [WIDTH_BITS-2:0]   px, w_half;
    logic [HEIGHT_BITS-2:0]  py, h_half;
    logic [DEPTH_BITS-2:0]   pz, d_half;
    logic [ROW_AW-1:0]       row_addr;
    logic [SLICE_AW-1:0]     slice_addr;
    logic [WIDTH_BITS:0]     column_inc;
    logic [HEIGHT_BITS:0]    row_inc;
    logic [DEPTH_BITS:0]     slice_inc;
    logic [PAIR_BITS-1:0]    pair_sum;
    logic [QUAD_BITS-1:0]    quad_sum;
    logic [CUBE_BITS-1:0]    cube_sum;

    // ------------------------------------------------------------------ input
    assign px     = column_count_reg[WIDTH_BITS-1:1];
    assign py     = row_count_reg[HEIGHT_BITS-1:1];
    assign pz     = slice_count_reg[DEPTH_BITS-1:1];
    assign w_half = dims.width[WIDTH_BITS-1:1];
    assign h_half = dims.height[HEIGHT_BITS-1:1];
    assign d_half = dims.depth[DEPTH_BITS-1:1];

    assign row_addr   = ROW_AW'(px);
    assign slice_addr = SLICE_AW'(py) * SLICE_AW'(ROW_DEPTH) + SLICE_AW'(px);

    assign s1_emit = s1_flags_reg.in_grid && s1_flags_reg.x_odd &&
                     s1_flags_reg.y_odd && s1_flags_reg.z_odd;
    assign s1_adv  = s1_valid_reg && !(s1_emit && result_valid_reg && result_stall);

    assign voxel_stall  = s1_valid_reg && !s1_adv;
    assign voxel_accept = voxel_valid && !voxel_stall;

    always_comb
    begin
        s1_flags_next.in_grid = (px < w_half) && (py < h_half) && (pz < d_half);
        s1_flags_next.x_odd   = column_count_reg[0];
        s1_flags_next.y_odd   = row_count_reg[0];
        s1_flags_next.z_odd   = slice_count_reg[0];
        s1_flags_next.last    = (px == w_half - 1'b1) && (py == h_half - 1'b1) &&
                                (pz == d_half - 1'b1);
    end

    // Counters wrap at the current sizes; a counter already beyond a size
    // wraps on its next advance.
    always_comb
    begin
        column_inc        = {1'b0, column_count_reg} + 1'b1;
        row_inc           = {1'b0, row_count_reg} + 1'b1;
        slice_inc         = {1'b0, slice_count_reg} + 1'b1;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        slice_count_next  = slice_count_reg;
        if (voxel_accept)
        begin
            if (column_inc >= {1'b0, dims.width})
            begin
                column_count_next = '0;
                if (row_inc >= {1'b0, dims.height})
                begin
                    row_count_next = '0;
                    if (slice_inc >= {1'b0, dims.depth})
                        slice_count_next = '0;
                    else
                        slice_count_next = slice_inc[DEPTH_BITS-1:0];
                end
                else
                begin
                    row_count_next = row_inc[HEIGHT_BITS-1:0];
                end
            end
            else
            begin
                column_count_next = column_inc[WIDTH_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (voxel_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && s1_emit)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            slice_count_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            even_voxel_reg   <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            slice_count_reg  <= slice_count_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_adv && s1_flags_reg.in_grid && !s1_flags_reg.x_odd)
                even_voxel_reg <= s1_voxel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (voxel_accept)
        begin
            s1_voxel_reg      <= voxel[VOXEL_BITS-1:0];
            s1_flags_reg      <= s1_flags_next;
            s1_row_addr_reg   <= row_addr;
            s1_slice_addr_reg <= slice_addr;
        end
    end

    // ---------------------------------------------------------------- buffers
    // Reads are issued as the voxel is accepted. The matching write comes at
    // least a full row earlier, so it has always landed by then.
    always_ff @(posedge clk)
    begin
        if (voxel_accept)
            row_rd_reg <= row_mem[row_addr];
        if (s1_adv && s1_flags_reg.in_grid && s1_flags_reg.x_odd && !s1_flags_reg.y_odd)
            row_mem[s1_row_addr_reg] <= pair_sum;
    end

    always_ff @(posedge clk)
    begin
        if (voxel_accept)
            slice_rd_reg <= slice_mem[slice_addr];
        if (s1_adv && s1_flags_reg.in_grid && s1_flags_reg.x_odd &&
            s1_flags_reg.y_odd && !s1_flags_reg.z_odd)
            slice_mem[s1_slice_addr_reg] <= quad_sum;
    end

    // --------------------------------------------------------------- datapath
    assign pair_sum = PAIR_BITS'(even_voxel_reg) + PAIR_BITS'(s1_voxel_reg);
    assign quad_sum = QUAD_BITS'(row_rd_reg) + QUAD_BITS'(pair_sum);
    assign cube_sum = CUBE_BITS'(slice_rd_reg) + CUBE_BITS'(quad_sum);

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit)
        begin
            average_reg     <= cube_sum[CUBE_BITS-1:3];
            volume_done_reg <= s1_flags_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign volume_done  = volume_done_reg;

`ifndef NO_ASSERTIONS
    // The input only stalls behind a voxel held in the working stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        voxel_stall |-> s1_valid_reg)
        else $error("input stalled with an empty working stage");

    // A voxel that completes a cube is kept while the output word waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_emit && result_valid_reg && result_stall |=>
        s1_valid_reg && $stable(s1_flags_reg))
        else $error("completing voxel lost while output was stalled");

    // A new output word only comes from a completing voxel leaving the stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !$past(result_valid_reg) |-> $past(s1_adv && s1_emit))
        else $error("output word appeared without a completed cube");

    // The output register is never overwritten while its word is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |-> !(s1_adv && s1_emit))
        else $error("stalled output word overwritten");
`endif

endmodule
